// ----- hw/rtl/anpt_pkg.sv -----
// Shared types and constants for the next-PC target calculator.
package anpt_pkg;

    // Request fields on the input side
    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] pc;
        logic [31:0] rn_value;
        logic [31:0] rm_value;
        logic [31:0] rs_value;
        logic        carry_flag;
    } in_t;

    // Result fields on the output side
    typedef struct packed {
        logic [1:0]  target_kind;
        logic [31:0] address;
    } out_t;

    // Target kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_DIRECT = 2'd1;
    localparam logic [1:0] KIND_LOAD   = 2'd2;

    // Functions the back end applies to its two operands
    localparam logic [2:0] FN_ADD = 3'd0;
    localparam logic [2:0] FN_AND = 3'd1;
    localparam logic [2:0] FN_EOR = 3'd2;
    localparam logic [2:0] FN_ORR = 3'd3;
    localparam logic [2:0] FN_MOV = 3'd4;
    localparam logic [2:0] FN_BIC = 3'd5;
    localparam logic [2:0] FN_MVN = 3'd6;

    // Instruction classes, bits 27:25
    localparam logic [2:0] CLS_DP_REG  = 3'b000;
    localparam logic [2:0] CLS_DP_IMM  = 3'b001;
    localparam logic [2:0] CLS_LS_IMM  = 3'b010;
    localparam logic [2:0] CLS_LS_REG  = 3'b011;
    localparam logic [2:0] CLS_LDM     = 3'b100;
    localparam logic [2:0] CLS_BRANCH  = 3'b101;

    // Data-processing opcodes, bits 24:21
    localparam logic [3:0] DP_AND = 4'd0;
    localparam logic [3:0] DP_EOR = 4'd1;
    localparam logic [3:0] DP_SUB = 4'd2;
    localparam logic [3:0] DP_RSB = 4'd3;
    localparam logic [3:0] DP_ADD = 4'd4;
    localparam logic [3:0] DP_ADC = 4'd5;
    localparam logic [3:0] DP_SBC = 4'd6;
    localparam logic [3:0] DP_RSC = 4'd7;
    localparam logic [3:0] DP_ORR = 4'd12;
    localparam logic [3:0] DP_MOV = 4'd13;
    localparam logic [3:0] DP_BIC = 4'd14;
    localparam logic [3:0] DP_MVN = 4'd15;

    // Shift types, bits 6:5
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    // Register number of the program counter
    localparam logic [3:0] REG_PC = 4'hf;

    // Classified work handed from the front end to the back end
    typedef struct packed {
        logic [1:0]  kind;
        logic        zero_none;
        logic [2:0]  fn;
        logic [31:0] op_a;
        logic [31:0] op_b;
        logic        carry_in;
    } work_t;

endpackage

// ----- hw/rtl/anpt_queue.sv -----
// Small synchronous queue of register slots with full/empty flags.
module anpt_queue #(
    parameter int  DEPTH  = 2,
    parameter type item_t = logic
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wr_data,
    output logic  full,
    input  logic  pop,
    output item_t rd_data,
    output logic  empty
);

    // DEPTH must be at least 2; the queue itself does not check it
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hw/rtl/anpt_front.sv -----
// Front end: decodes the instruction, selects the base, runs the barrel shifter.
module anpt_front (
    input  anpt_pkg::in_t   req,
    input  logic [31:0]     pc_mask,
    output anpt_pkg::work_t work
);

    // Rotate right by 0..31
    function automatic logic [31:0] rotr(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] dbl;
        dbl  = {v, v} >> n;
        return dbl[31:0];
    endfunction

    // Shift by an immediate amount; zero amounts encode LSR #32, ASR #32, RRX
    function automatic logic [31:0] shift_imm(input logic [31:0] v, input logic [1:0] typ,
                                              input logic [4:0] amt, input logic c);
        logic [31:0] r;
        case (typ)
            anpt_pkg::SH_LSL: r = v << amt;
            anpt_pkg::SH_LSR: r = (amt == 5'd0) ? 32'd0 : (v >> amt);
            anpt_pkg::SH_ASR: r = (amt == 5'd0) ? {32{v[31]}} : 32'($signed(v) >>> amt);
            anpt_pkg::SH_ROR: r = (amt == 5'd0) ? {c, v[31:1]} : rotr(v, amt);
            default:          r = v;
        endcase
        return r;
    endfunction

    // Shift by a register amount; 32 and above saturate, but ROR uses the low five bits
    function automatic logic [31:0] shift_reg(input logic [31:0] v, input logic [1:0] typ,
                                              input logic [7:0] amt);
        logic [31:0] r;
        logic        big;
        big = (amt[7:5] != 3'd0);
        if (amt == 8'd0)
        begin
            r = v;
        end
        else
        begin
            case (typ)
                anpt_pkg::SH_LSL: r = big ? 32'd0 : (v << amt[4:0]);
                anpt_pkg::SH_LSR: r = big ? 32'd0 : (v >> amt[4:0]);
                anpt_pkg::SH_ASR: r = big ? {32{v[31]}} : 32'($signed(v) >>> amt[4:0]);
                anpt_pkg::SH_ROR: r = rotr(v, amt[4:0]);
                default:          r = v;
            endcase
        end
        return r;
    endfunction

    logic [31:0] insn;
    logic [31:0] base;
    logic [31:0] op2;
    logic [31:0] ls_off;
    logic [4:0]  list_cnt;
    logic [31:0] lm_off;
    logic [31:0] br_disp;
    logic        c;

    assign insn = req.instruction;
    assign c    = req.carry_flag;

    // Base register, PC reads as PC+8 under the mask
    assign base = (insn[19:16] == anpt_pkg::REG_PC) ? ((req.pc + 32'd8) & pc_mask)
                                                   : req.rn_value;

    // Operand 2 for data processing
    always_comb
    begin
        if (insn[25])
        begin
            op2 = rotr({24'd0, insn[7:0]}, {insn[11:8], 1'b0});
        end
        else if (insn[4])
        begin
            op2 = shift_reg(req.rm_value, insn[6:5], req.rs_value[7:0]);
        end
        else
        begin
            op2 = shift_imm(req.rm_value, insn[6:5], insn[11:7], c);
        end
    end

    // Single load offset
    assign ls_off = insn[25] ? shift_imm(req.rm_value, insn[6:5], insn[11:7], c)
                             : {20'd0, insn[11:0]};

    // Block load: offset of the PC word from the register count
    assign list_cnt = 5'($countones(insn[15:0]));
    always_comb
    begin
        if (insn[23])
        begin
            lm_off = {25'd0, list_cnt, 2'b00} - (insn[24] ? 32'd0 : 32'd4);
        end
        else
        begin
            lm_off = insn[24] ? 32'hffff_fffc : 32'd0;
        end
    end

    // Branch displacement including the pipeline offset
    assign br_disp = {{6{insn[23]}}, insn[23:0], 2'b00} + 32'd8;

    // Classification
    always_comb
    begin
        work.kind      = anpt_pkg::KIND_NONE;
        work.zero_none = 1'b0;
        work.fn        = anpt_pkg::FN_ADD;
        work.op_a      = base;
        work.op_b      = op2;
        work.carry_in  = 1'b0;
        case (insn[27:25])
            anpt_pkg::CLS_DP_REG,
            anpt_pkg::CLS_DP_IMM:
            begin
                if (insn[15:12] == anpt_pkg::REG_PC)
                begin
                    work.kind      = anpt_pkg::KIND_DIRECT;
                    work.zero_none = 1'b1;
                    case (insn[24:21])
                        anpt_pkg::DP_AND: work.fn = anpt_pkg::FN_AND;
                        anpt_pkg::DP_EOR: work.fn = anpt_pkg::FN_EOR;
                        anpt_pkg::DP_SUB:
                        begin
                            work.op_b     = ~op2;
                            work.carry_in = 1'b1;
                        end
                        anpt_pkg::DP_RSB:
                        begin
                            work.op_a     = op2;
                            work.op_b     = ~base;
                            work.carry_in = 1'b1;
                        end
                        anpt_pkg::DP_ADD: work.carry_in = 1'b0;
                        anpt_pkg::DP_ADC: work.carry_in = c;
                        anpt_pkg::DP_SBC:
                        begin
                            work.op_b     = ~op2;
                            work.carry_in = c;
                        end
                        anpt_pkg::DP_RSC:
                        begin
                            work.op_a     = op2;
                            work.op_b     = ~base;
                            work.carry_in = c;
                        end
                        anpt_pkg::DP_ORR: work.fn = anpt_pkg::FN_ORR;
                        anpt_pkg::DP_MOV: work.fn = anpt_pkg::FN_MOV;
                        anpt_pkg::DP_BIC: work.fn = anpt_pkg::FN_BIC;
                        anpt_pkg::DP_MVN: work.fn = anpt_pkg::FN_MVN;
                        // compares write no register
                        default:          work.kind = anpt_pkg::KIND_NONE;
                    endcase
                end
            end
            anpt_pkg::CLS_LS_IMM,
            anpt_pkg::CLS_LS_REG:
            begin
                if (insn[20] && (insn[15:12] == anpt_pkg::REG_PC))
                begin
                    work.kind = anpt_pkg::KIND_LOAD;
                    if (!insn[24])
                    begin
                        // post-indexed: plain base
                        work.op_b = 32'd0;
                    end
                    else if (insn[23])
                    begin
                        work.op_b = ls_off;
                    end
                    else
                    begin
                        work.op_b     = ~ls_off;
                        work.carry_in = 1'b1;
                    end
                end
            end
            anpt_pkg::CLS_LDM:
            begin
                if (insn[20] && insn[15])
                begin
                    work.kind = anpt_pkg::KIND_LOAD;
                    work.op_b = lm_off;
                end
            end
            anpt_pkg::CLS_BRANCH:
            begin
                work.op_a      = req.pc;
                work.op_b      = br_disp;
                work.zero_none = 1'b1;
                if ((br_disp != 32'd0) && (br_disp != 32'd4))
                begin
                    work.kind = anpt_pkg::KIND_DIRECT;
                end
            end
            default: work.kind = anpt_pkg::KIND_NONE;
        endcase
    end

endmodule

// ----- hw/rtl/anpt_back.sv -----
// Back end: adder and logic unit that produce the final target.
module anpt_back (
    input  anpt_pkg::work_t work,
    output anpt_pkg::out_t  result
);

    logic [31:0] sum;
    logic [31:0] r;
    logic        none;

    assign sum = work.op_a + work.op_b + 32'(work.carry_in);

    // Function select
    always_comb
    begin
        case (work.fn)
            anpt_pkg::FN_ADD: r = sum;
            anpt_pkg::FN_AND: r = work.op_a & work.op_b;
            anpt_pkg::FN_EOR: r = work.op_a ^ work.op_b;
            anpt_pkg::FN_ORR: r = work.op_a | work.op_b;
            anpt_pkg::FN_MOV: r = work.op_b;
            anpt_pkg::FN_BIC: r = work.op_a & ~work.op_b;
            anpt_pkg::FN_MVN: r = ~work.op_b;
            default:          r = sum;
        endcase
    end

    // A zero direct target means no target
    assign none = (work.kind == anpt_pkg::KIND_NONE) || (work.zero_none && (r == 32'd0));

    assign result.target_kind = none ? anpt_pkg::KIND_NONE : work.kind;
    assign result.address     = none ? 32'd0 : r;

endmodule

// ----- hw/rtl/arm_next_pc_target.sv -----
// Top level of the next-PC target calculator: front end, queues, back end.
//
// Usage:
//   Input queue side: drive in_item and raise push; a request is taken on a
//   clock edge with push high and full low.
//   Result queue side: while empty is low, out_item holds the oldest result;
//   it is taken on a clock edge with pop high. Every request gives exactly
//   one result (target_kind 0 with address 0 when there is no target).
//   pc_mask_we/pc_mask_data write the PC mask register; write only while idle.
// Flow and throughput:
//   A result appears (empty low) once its request has passed both queues: the
//   decode/shift front end writes the middle queue at the accepting edge, and
//   the adder/logic back end moves it into the result queue once there is room.
//   One request per cycle is sustained while results are taken; the front end
//   and back end each handle one request per cycle while the result queue has room.
// Reset: both queues empty, pc_mask set to all ones.
// Stall: when pop stays low the result queue fills, the back end holds, the
//   middle queue fills and full rises until results are taken.
module arm_next_pc_target #(
    parameter int MID_DEPTH = 2,
    parameter int OUT_DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  anpt_pkg::in_t   in_item,
    output logic            full,
    input  logic            pop,
    output anpt_pkg::out_t  out_item,
    output logic            empty,
    input  logic            pc_mask_we,
    input  logic [31:0]     pc_mask_data
);

    logic [31:0]     pc_mask_reg, pc_mask_next;
    anpt_pkg::work_t front_work;
    anpt_pkg::work_t mid_work;
    logic            mid_empty;
    logic            mid_pop;
    anpt_pkg::out_t  back_result;
    logic            out_full;

    // PC mask register
    assign pc_mask_next = pc_mask_we ? pc_mask_data : pc_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_mask_reg <= 32'hffff_ffff;
        end
        else
        begin
            pc_mask_reg <= pc_mask_next;
        end
    end

    // Decode and operand preparation
    anpt_front u_front (
        .req     (in_item),
        .pc_mask (pc_mask_reg),
        .work    (front_work)
    );

    // Queue between front and back
    anpt_queue #(
        .DEPTH  (MID_DEPTH),
        .item_t (anpt_pkg::work_t)
    ) u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_work),
        .full    (full),
        .pop     (mid_pop),
        .rd_data (mid_work),
        .empty   (mid_empty)
    );

    // Back end moves one request whenever the result queue has room
    assign mid_pop = ~mid_empty & ~out_full;

    anpt_back u_back (
        .work   (mid_work),
        .result (back_result)
    );

    // Result queue
    anpt_queue #(
        .DEPTH  (OUT_DEPTH),
        .item_t (anpt_pkg::out_t)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (mid_pop),
        .wr_data (back_result),
        .full    (out_full),
        .pop     (pop),
        .rd_data (out_item),
        .empty   (empty)
    );

`ifndef SYNTH
    // No target always reports address zero
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (out_item.target_kind == anpt_pkg::KIND_NONE)) |-> (out_item.address == 32'd0))
        else $error("no-target result with nonzero address");

    // Kind code three is never produced
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_item.target_kind != 2'd3))
        else $error("invalid target kind");

    // An accepted request is in the middle queue on the next cycle
    a_mid_filled: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> !mid_empty)
        else $error("accepted request lost before back end");
`endif

endmodule
